// ===== rtl/core/pmac_pkg.sv =====
// Shared types and constants for the Poly1305 authenticator.
package pmac_pkg;

  typedef struct packed {
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  byte_count;
    logic        last_block;
  } in_t;

  typedef struct packed {
    logic [63:0] tag_low;
    logic [63:0] tag_high;
  } out_t;

  // One classified block as handed from the front end to the multiply engine.
  typedef struct packed {
    logic [128:0] msg;
    logic         absorb;
    logic         last;
  } cmd_t;

  localparam logic [127:0] RClamp = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
  localparam int unsigned  LimbW  = 26;
  localparam int unsigned  NLimb  = 5;
  localparam int unsigned  HmW    = 27;

  localparam logic [1:0] RegRLow  = 2'd0;
  localparam logic [1:0] RegRHigh = 2'd1;
  localparam logic [1:0] RegSLow  = 2'd2;
  localparam logic [1:0] RegSHigh = 2'd3;

endpackage

// ===== rtl/core/poly1305_mac_engine.sv =====
// Poly1305 authenticator top level: APB key registers, front end, queue and engine.
// An absorbed block passes from the pop through one add, five row multiplies through five
// 27x26 lanes, one drain and two reduction steps before the engine is idle again.
// A last block then finalizes into the output register, waiting while the output is full.
// The shared multiply lanes set the sustained rate: a new block is popped only when idle.
// Reset clears the key registers, the accumulator, the queue and the output.
module poly1305_mac_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pmac_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pmac_pkg::out_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready
);

  logic [63:0] r_low_q, r_high_q, s_low_q, s_high_q;
  logic        full, empty, pop, push;
  pmac_pkg::cmd_t cmd_in, cmd_out;
  logic [1:0]  idx;

  assign pready     = 1'b1;
  assign idx        = paddr[4:3];
  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;

  always_comb begin
    unique case (idx)
      pmac_pkg::RegRLow:  prdata = r_low_q;
      pmac_pkg::RegRHigh: prdata = r_high_q;
      pmac_pkg::RegSLow:  prdata = s_low_q;
      pmac_pkg::RegSHigh: prdata = s_high_q;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_low_q  <= '0;
      r_high_q <= '0;
      s_low_q  <= '0;
      s_high_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        pmac_pkg::RegRLow:  r_low_q  <= pwdata;
        pmac_pkg::RegRHigh: r_high_q <= pwdata;
        pmac_pkg::RegSLow:  s_low_q  <= pwdata;
        pmac_pkg::RegSHigh: s_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  pmac_front u_front (
    .in_data_i (in_data_i),
    .cmd_o     (cmd_in)
  );

  pmac_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd_in),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (cmd_out)
  );

  pmac_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .r_i         ({r_high_q, r_low_q}),
    .s_i         ({s_high_q, s_low_q}),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/pmac_front.sv =====
// Front end: pads each incoming block and classifies it for the engine.
module pmac_front (
  input  pmac_pkg::in_t  in_data_i,
  output pmac_pkg::cmd_t cmd_o
);

  logic [4:0]   n;
  logic [127:0] blk;
  logic [127:0] mask;
  logic [127:0] pad;

  always_comb begin
    n    = (in_data_i.byte_count > 5'd16) ? 5'd16 : in_data_i.byte_count;
    blk  = {in_data_i.block_high, in_data_i.block_low};
    pad  = 128'd1 << {n[3:0], 3'b000};
    mask = pad - 128'd1;
    if (n == 5'd16) begin
      cmd_o.msg = {1'b1, blk};
    end else begin
      cmd_o.msg = {1'b0, (blk & mask) | pad};
    end
    cmd_o.absorb = (n != 5'd0);
    cmd_o.last   = in_data_i.last_block;
  end

endmodule

// ===== rtl/core/pmac_fifo.sv =====
// Two-entry queue between the front end and the multiply engine.
module pmac_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pmac_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output pmac_pkg::cmd_t pop_data_o
);

  pmac_pkg::cmd_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/pmac_engine.sv =====
// Back end: accumulate-multiply modulo 2^130-5 and tag finalization.
module pmac_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  pmac_pkg::cmd_t cmd_i,
  output logic           pop_o,
  input  logic [127:0]   r_i,
  input  logic [127:0]   s_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pmac_pkg::out_t out_data_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StAdd   = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StRed1  = 3'd4;
  localparam logic [2:0] StRed2  = 3'd5;
  localparam logic [2:0] StFin   = 3'd6;

  logic [2:0]   state_q, state_d;
  logic [130:0] h_q, h_d;
  logic [134:0] hm_q, hm_d;
  logic [256:0] acc_q, acc_d;
  logic [52:0]  prod_q [pmac_pkg::NLimb];
  logic [52:0]  prod_d [pmac_pkg::NLimb];
  logic         pv_q, pv_d;
  logic [2:0]   k_q, k_d;
  logic [128:0] msg_q;
  logic         last_q;
  logic         out_valid_q, out_valid_d;
  pmac_pkg::out_t out_q, out_d;

  logic [129:0] rc;
  logic [25:0]  rl;
  logic [160:0] row;
  logic [130:0] v;
  logic [130:0] g;
  logic [129:0] hr;
  logic [127:0] tag;
  logic         out_free;

  assign rc          = {2'b00, r_i & pmac_pkg::RClamp};
  assign rl          = rc[k_q*pmac_pkg::LimbW +: pmac_pkg::LimbW];
  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == StIdle) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    row = '0;
    for (int i = 0; i < pmac_pkg::NLimb; i++) begin
      row = row + ({108'd0, prod_q[i]} << (pmac_pkg::HmW * i));
    end
    for (int i = 0; i < pmac_pkg::NLimb; i++) begin
      prod_d[i] = 53'(hm_q[i*pmac_pkg::HmW +: pmac_pkg::HmW]) * 53'(rl);
    end
  end

  // Fold bits above 2^130 back in with weight five, twice.
  assign v   = 131'(acc_q[129:0]) + 131'({acc_q[256:130], 2'b00}) + 131'(acc_q[256:130]);
  assign g   = h_q + 131'd5;
  assign hr  = g[130] ? g[129:0] : h_q[129:0];
  assign tag = hr[127:0] + s_i;

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    hm_d        = hm_q;
    acc_d       = acc_q;
    pv_d        = 1'b0;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          if (cmd_i.absorb) begin
            state_d = StAdd;
          end else if (cmd_i.last) begin
            state_d = StFin;
          end
        end
      end
      StAdd: begin
        hm_d    = 135'(h_q) + 135'(msg_q);
        acc_d   = '0;
        k_d     = 3'd4;
        state_d = StMul;
      end
      StMul: begin
        pv_d = 1'b1;
        if (pv_q) begin
          acc_d = (acc_q << pmac_pkg::LimbW) + 257'(row);
        end
        if (k_q == 3'd0) begin
          state_d = StDrain;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      StDrain: begin
        acc_d   = (acc_q << pmac_pkg::LimbW) + 257'(row);
        state_d = StRed1;
      end
      StRed1: begin
        acc_d   = 257'(v);
        state_d = StRed2;
      end
      StRed2: begin
        h_d     = 131'(acc_q[129:0]) + (acc_q[130] ? 131'd5 : 131'd0);
        state_d = last_q ? StFin : StIdle;
      end
      StFin: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.tag_low  = tag[63:0];
          out_d.tag_high = tag[127:64];
          h_d            = '0;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    hm_q  <= hm_d;
    acc_q <= acc_d;
    k_q   <= k_d;
    out_q <= out_d;
    for (int i = 0; i < pmac_pkg::NLimb; i++) begin
      prod_q[i] <= prod_d[i];
    end
    if (pop_o) begin
      msg_q  <= cmd_i.msg;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      h_q         <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== tb/poly1305_mac_engine_test.sv =====
// Self-checking testbench for the Poly1305 authenticator engine.
`timescale 1ns / 1ps

module poly1305_mac_engine_test;

  localparam logic [129:0] Prime = (130'd1 << 130) - 130'd5;
  localparam int unsigned CycleLimit = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pmac_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pmac_pkg::out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  poly1305_mac_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o,
    .out_ready_i, .out_data_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: key registers and the running accumulator.
  logic [63:0] key_r_low, key_r_high, key_s_low, key_s_high;
  logic [129:0] acc_h;

  pmac_pkg::in_t block_queue[$];
  pmac_pkg::out_t tag_queue[$];
  int unsigned error_count = 0;
  int unsigned tags_seen = 0;
  int unsigned blocks_sent = 0;
  int unsigned cycle_count = 0;
  bit hold_sender = 1'b0;
  bit in_accepted = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  // Absorb one block into acc_h with the current key, return a tag on last.
  function automatic bit mac_step(input pmac_pkg::in_t blk, output pmac_pkg::out_t tag);
    logic [127:0] r_key;
    logic [128:0] msg;
    logic [259:0] prod;
    logic [130:0] fin;
    int unsigned nbytes;
    r_key = {key_r_high, key_r_low} & pmac_pkg::RClamp;
    nbytes = (blk.byte_count > 16) ? 16 : blk.byte_count;
    msg = {1'b0, blk.block_high, blk.block_low};
    if (nbytes == 16) begin
      msg[128] = 1'b1;
    end else if (nbytes > 0) begin
      msg = msg & ((129'd1 << (8 * nbytes)) - 129'd1);
      msg[8 * nbytes] = 1'b1;
    end
    if (nbytes > 0) begin
      prod = (260'(acc_h) + 260'(msg)) * 260'(r_key);
      acc_h = 130'(prod % 260'(Prime));
    end
    tag = '0;
    if (!blk.last_block) return 1'b0;
    fin = 131'(acc_h) + 131'({key_s_high, key_s_low});
    tag.tag_low = fin[63:0];
    tag.tag_high = fin[127:64];
    acc_h = '0;
    return 1'b1;
  endfunction

  // Tags still owed by blocks that have not been presented yet.
  function automatic int unsigned pending_lasts();
    int unsigned cnt;
    cnt = 0;
    foreach (block_queue[i]) begin
      if (block_queue[i].last_block) cnt++;
    end
    return cnt;
  endfunction

  // Configuration write: setup cycle, then access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 3; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pmac_pkg::RegRLow:  key_r_low = val;
      pmac_pkg::RegRHigh: key_r_high = val;
      pmac_pkg::RegSLow:  key_s_low = val;
      default:            key_s_high = val;
    endcase
  endtask

  task automatic load_key(input logic [63:0] rl, rh, sl, sh);
    write_reg(pmac_pkg::RegRLow, rl);
    write_reg(pmac_pkg::RegRHigh, rh);
    write_reg(pmac_pkg::RegSLow, sl);
    write_reg(pmac_pkg::RegSHigh, sh);
  endtask

  // Queue one block and predict its result.
  task automatic send_block(input logic [63:0] lo, hi, input logic [4:0] cnt,
                            input logic last);
    pmac_pkg::in_t blk;
    pmac_pkg::out_t tag;
    blk.block_low = lo; blk.block_high = hi;
    blk.byte_count = cnt; blk.last_block = last;
    block_queue.push_back(blk);
    if (mac_step(blk, tag)) tag_queue.push_back(tag);
  endtask

  task automatic drain_all();
    while (block_queue.size() != 0 || in_valid_i || tag_queue.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // Random message of well-formed blocks, occasionally with odd counts mid-message.
  task automatic send_message();
    int nblk;
    logic [4:0] cnt;
    nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
    for (int b = 0; b < nblk; b++) begin
      cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
      send_block(edge64(), edge64(), cnt, 1'b0);
    end
    cnt = ($urandom_range(0, 2) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
    send_block(edge64(), edge64(), cnt, 1'b1);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_accepted) begin
        if (gap_left > 0 || hold_sender || block_queue.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i <= block_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      out_ready_i <= ((cycle_count / 400) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: records input transfers and checks every tag transfer.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    in_accepted <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      blocks_sent <= blocks_sent + 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      tags_seen <= tags_seen + 1;
      if (tag_queue.size() == 0) begin
        $error("unexpected tag transfer: %h %h", out_data_o.tag_low, out_data_o.tag_high);
        error_count <= error_count + 1;
      end else begin
        if (out_data_o.tag_low !== tag_queue[0].tag_low) begin
          $error("tag_low expected %h actual %h", tag_queue[0].tag_low,
                 out_data_o.tag_low);
          error_count <= error_count + 1;
        end
        if (out_data_o.tag_high !== tag_queue[0].tag_high) begin
          $error("tag_high expected %h actual %h", tag_queue[0].tag_high,
                 out_data_o.tag_high);
          error_count <= error_count + 1;
        end
        void'(tag_queue.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d tags outstanding", tag_queue.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    key_r_low = '0; key_r_high = '0; key_s_low = '0; key_s_high = '0;
    acc_h = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero key, then a fixed key with extremes and special counts.
    send_block('1, '1, 5'd16, 1'b1);
    drain_all();
    load_key(64'h0803_3f7d_f300_b485, 64'h0349_2a00_d6fe_ae2d,
             64'ha8e8_f27b_f02f_c741, 64'h1bf5_49a9_ba6e_b1b6);
    send_block('0, '0, 5'd0, 1'b1);
    send_block('1, '1, 5'd16, 1'b0);
    send_block('1, '1, 5'd16, 1'b1);
    send_block('1, '1, 5'd31, 1'b1);
    send_block('1, '1, 5'd1, 1'b0);
    send_block('1, '1, 5'd7, 1'b1);
    send_block('1, '1, 5'd8, 1'b1);
    send_block('1, '1, 5'd9, 1'b1);
    send_block('1, '1, 5'd15, 1'b1);
    send_block('0, '0, 5'd16, 1'b0);
    send_block('0, '0, 5'd0, 1'b0);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd16, 1'b1);
    drain_all();
    load_key('1, '1, '1, '1);
    for (int i = 0; i < 6; i++) send_block('1, '1, 5'd16, i == 5);
    send_block(rand64(), rand64(), 5'd3, 1'b1);
    // Key change in the middle of a message.
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    drain_all();
    load_key(rand64(), rand64(), '0, '1);
    send_block(rand64(), rand64(), 5'd12, 1'b1);
    drain_all();

    for (int phase = 0; phase < 6; phase++) begin
      load_key(rand64(), rand64(), rand64(), rand64());
      while (block_queue.size() < 250 && blocks_sent + 260 < 1500 * (phase + 1) / 6 + 260)
        send_message();
      if (phase == 2) begin
        // Let traffic build up, then stop sending until every owed tag is back.
        repeat (200) @(posedge clk_i);
        hold_sender = 1'b1;
        while (in_valid_i) @(posedge clk_i);
        while (tag_queue.size() != pending_lasts()) @(posedge clk_i);
        repeat (20) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      drain_all();
    end

    $display("sent %0d blocks, checked %0d tags across several key settings",
             blocks_sent, tags_seen);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
